### hw/rtl/mfd_pkg.sv
// Shared types, constants and helper functions of the flow accumulation block.
package mfd_pkg;

	localparam int FLOW_W   = 48;
	localparam int ELEV_W   = 32;
	localparam int LOG_W    = 21;
	localparam int MANT_W   = 31;
	localparam int EXP_W    = 24;
	localparam int WGT_W    = 16;
	localparam int SUM_W    = 19;
	localparam int PROD_W   = 64;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_ROUTE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_NONE  = 2'd3;

	localparam logic [1:0] REG_COLUMNS = 2'd0;
	localparam logic [1:0] REG_ROWS    = 2'd1;
	localparam logic [1:0] REG_LENGTH  = 2'd2;
	localparam logic [1:0] REG_AREA    = 2'd3;

	localparam logic [16:0]      POWER_Q16  = 17'd72090;
	localparam logic [EXP_W-1:0] LOG_OFFSET = EXP_W'(33 * 65536);
	localparam logic [EXP_W-1:0] DIAG_HALF  = EXP_W'(32768);
	localparam logic [EXP_W-1:0] EXP_SPAN_Q = EXP_W'(72 * 65536);
	localparam logic [7:0]       EXP_SPAN   = 8'd72;

	typedef logic signed [1:0] step_t;
	typedef step_t step_table_t [8];
	localparam step_table_t STEP_ROW = '{2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1};
	localparam step_table_t STEP_COL = '{2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1};

	typedef logic [MANT_W-1:0] root_table_t [16];

	function automatic logic [63:0] int_sqrt(input logic [63:0] value);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = value;
		r = '0;
		b = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic root_table_t build_roots();
		root_table_t t;
		logic [63:0] cur;
		cur = int_sqrt(64'd2 << 60);
		t[0] = MANT_W'(cur);
		for (int k = 1; k < 16; k++) begin
			cur = int_sqrt(cur << 30);
			t[k] = MANT_W'(cur);
		end
		return t;
	endfunction

	localparam root_table_t ROOT_TABLE = build_roots();

	function automatic logic [FLOW_W-1:0] sat_add(input logic [FLOW_W-1:0] a,
		input logic [FLOW_W-1:0] b);
		logic [FLOW_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[FLOW_W] ? {FLOW_W{1'b1}} : s[FLOW_W-1:0];
	endfunction

endpackage

### hw/rtl/mfd_flow_accumulation_core.sv
// Top level: grid memories, request sequencer and result register.
//
// Input channel s_*: one request per transaction. s_tuser carries the request type
// (write elevation, route cell, read flow); type three is dropped without a reply.
// Output channel m_*: one reply per request, flow in m_tdata for a read (zero otherwise), echoed type in m_tuser.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must do so
// only while the block is idle, which the block itself does not enforce.
// Reset initialises the control and configuration registers, then a sweep zeroes
// the flow memory, one entry a cycle, with s_tready low.
// Requests are handled one at a time. A route reads the centre, takes one log2 of the
// cell length, then per neighbour inside the grid one elevation read, per lower
// neighbour (receiver) one log2, per receiver one exp2, and per receiver with a
// non-zero weight one flow read, one multiply and a division before the write-back.
// A new request is taken while the reply waits in the output register; a stalled
// m_tready holds the next reply in the sequencer.
module mfd_flow_accumulation_core #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // row[7:0], col[15:8], elevation[47:16], no_data[48], zero
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // flow_value[47:0]
	output logic [1:0]  m_tuser,   // reply_kind[1:0]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);
	localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
	localparam int AW = $clog2(CELL_COUNT);
	localparam int FW = mfd_pkg::FLOW_W;
	localparam int EW = mfd_pkg::EXP_W;

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_READ   = 4'd2;
	localparam logic [3:0] ST_CENTER = 4'd3;
	localparam logic [3:0] ST_LEN    = 4'd4;
	localparam logic [3:0] ST_NADDR  = 4'd5;
	localparam logic [3:0] ST_NDATA  = 4'd6;
	localparam logic [3:0] ST_NLOG   = 4'd7;
	localparam logic [3:0] ST_NPOW   = 4'd8;
	localparam logic [3:0] ST_WSTART = 4'd9;
	localparam logic [3:0] ST_WEXP   = 4'd10;
	localparam logic [3:0] ST_WEND   = 4'd11;
	localparam logic [3:0] ST_UADDR  = 4'd12;
	localparam logic [3:0] ST_UMUL   = 4'd13;
	localparam logic [3:0] ST_UDIV   = 4'd14;
	localparam logic [3:0] ST_REPLY  = 4'd15;

	logic [8:0]   grid_columns_q;
	logic [8:0]   grid_rows_q;
	logic [31:0]  cell_length_q;
	logic [FW-1:0] cell_area_q;

	logic [3:0]   state_q;
	logic [AW-1:0] clr_q;
	logic [2:0]   i_q;
	logic [7:0]   take_q;
	logic         out_valid_q;

	logic [1:0]   kind_q;
	logic [7:0]   r_q;
	logic [7:0]   c_q;
	logic [AW-1:0] a_q;
	logic [31:0]  elev_c_q;
	logic [FW-1:0] f_q;
	logic [mfd_pkg::LOG_W-1:0] len_log_q;
	logic [40:0]  epow_s1;
	logic [EW-1:0] e_q [8];
	logic [EW-1:0] emax_q;
	logic [mfd_pkg::WGT_W-1:0] w_q [8];
	logic [mfd_pkg::SUM_W-1:0] sum_q;
	logic [6:0]   shift_q;
	logic [mfd_pkg::PROD_W-1:0] mul_s1;
	logic [FW-1:0] reply_val_q;
	logic [FW-1:0] out_data_q;
	logic [1:0]   out_kind_q;

	logic [32:0]  elev_mem [CELL_COUNT];
	logic [FW-1:0] flow_mem [CELL_COUNT];
	logic [32:0]  elev_rd;
	logic [FW-1:0] flow_rd;

	logic         elev_we, elev_re, flow_we, flow_re;
	logic [AW-1:0] elev_wa, elev_ra, flow_wa, flow_ra;
	logic [32:0]  elev_wd;
	logic [FW-1:0] flow_wd;

	logic [12:0]  used_cols, used_rows;
	logic [7:0]   in_row, in_col;
	logic         in_inside;
	logic [AW-1:0] in_addr;
	logic         accept;

	logic signed [10:0] nr_s, nc_s;
	logic         nbr_in;
	logic [AW-1:0] nbr_addr;
	logic [32:0]  drop;
	logic         drop_pos;

	logic         log_start, log_done;
	logic [31:0]  log_operand;
	logic [mfd_pkg::LOG_W-1:0] log_result;
	logic         exp_start, exp_done;
	logic [mfd_pkg::MANT_W-1:0] exp_result;
	logic         div_start, div_done;
	logic [FW-1:0] div_q;

	logic [EW-1:0] l_val;
	logic [EW-1:0] x_sum, x_dif;
	logic [7:0]   x_int;
	logic [6:0]   shift_val;
	logic [mfd_pkg::WGT_W-1:0] w_val;
	logic         reply_free;

	assign used_cols = (13'(grid_columns_q) > 13'(MAX_COLUMNS)) ? 13'(MAX_COLUMNS)
		: 13'(grid_columns_q);
	assign used_rows = (13'(grid_rows_q) > 13'(MAX_ROWS)) ? 13'(MAX_ROWS)
		: 13'(grid_rows_q);

	assign in_row    = s_tdata[7:0];
	assign in_col    = s_tdata[15:8];
	assign in_inside = (13'(in_row) < used_rows) && (13'(in_col) < used_cols);
	assign in_addr   = AW'(32'(in_row) * MAX_COLUMNS + 32'(in_col));
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;

	assign nr_s = $signed({3'b000, r_q}) + {{9{mfd_pkg::STEP_ROW[i_q][1]}}, mfd_pkg::STEP_ROW[i_q]};
	assign nc_s = $signed({3'b000, c_q}) + {{9{mfd_pkg::STEP_COL[i_q][1]}}, mfd_pkg::STEP_COL[i_q]};
	assign nbr_in = !nr_s[10] && !nc_s[10] && (13'(nr_s[9:0]) < used_rows)
		&& (13'(nc_s[9:0]) < used_cols);
	assign nbr_addr = AW'(32'(nr_s[9:0]) * MAX_COLUMNS + 32'(nc_s[9:0]));

	assign drop     = {elev_c_q[31], elev_c_q} - {elev_rd[31], elev_rd[31:0]};
	assign drop_pos = !drop[32] && (drop != 33'd0);

	assign l_val = EW'(log_result) + mfd_pkg::LOG_OFFSET - EW'(len_log_q)
		- (i_q[0] ? mfd_pkg::DIAG_HALF : '0);

	assign x_sum     = e_q[i_q] + mfd_pkg::EXP_SPAN_Q;
	assign x_dif     = (x_sum > emax_q) ? x_sum - emax_q : '0;
	assign x_int     = x_dif[23:16];
	assign shift_val = (x_int >= mfd_pkg::EXP_SPAN) ? 7'd15
		: 7'(mfd_pkg::EXP_SPAN - x_int) + 7'd15;
	assign w_val     = (shift_q >= 7'd31) ? '0 : mfd_pkg::WGT_W'(exp_result >> shift_q);

	assign reply_free = !out_valid_q || m_tready;

	always_comb begin
		elev_we     = 1'b0;
		elev_wa     = in_addr;
		elev_wd     = {s_tdata[48], s_tdata[47:16]};
		elev_re     = 1'b0;
		elev_ra     = in_addr;
		flow_we     = 1'b0;
		flow_wa     = a_q;
		flow_wd     = '0;
		flow_re     = 1'b0;
		flow_ra     = in_addr;
		log_start   = 1'b0;
		log_operand = cell_length_q;
		exp_start   = 1'b0;
		div_start   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				flow_we = 1'b1;
				flow_wa = clr_q;
			end
			ST_IDLE: begin
				if (accept && in_inside) begin
					elev_we = (s_tuser == mfd_pkg::REQ_WRITE);
					elev_re = (s_tuser == mfd_pkg::REQ_ROUTE);
					flow_re = (s_tuser == mfd_pkg::REQ_ROUTE) || (s_tuser == mfd_pkg::REQ_READ);
				end
			end
			ST_CENTER: begin
				if (!elev_rd[32]) begin
					flow_we   = 1'b1;
					flow_wd   = mfd_pkg::sat_add(flow_rd, cell_area_q);
					log_start = 1'b1;
				end
			end
			ST_NADDR: begin
				elev_re = nbr_in;
				elev_ra = nbr_addr;
			end
			ST_NDATA: begin
				log_start   = !elev_rd[32] && drop_pos;
				log_operand = drop[31:0];
			end
			ST_WSTART: begin
				exp_start = take_q[i_q];
			end
			ST_UADDR: begin
				flow_re = take_q[i_q] && (w_q[i_q] != '0);
				flow_ra = nbr_addr;
			end
			ST_UMUL: begin
				div_start = 1'b1;
			end
			ST_UDIV: begin
				flow_we = div_done;
				flow_wa = nbr_addr;
				flow_wd = mfd_pkg::sat_add(flow_rd, div_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (elev_we) begin
			elev_mem[elev_wa] <= elev_wd;
		end
		if (elev_re) begin
			elev_rd <= elev_mem[elev_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (flow_we) begin
			flow_mem[flow_wa] <= flow_wd;
		end
		if (flow_re) begin
			flow_rd <= flow_mem[flow_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= 9'd256;
			grid_rows_q    <= 9'd256;
			cell_length_q  <= 32'd65536;
			cell_area_q    <= FW'(65536);
		end else if (cfg_we) begin
			unique case (cfg_index)
				mfd_pkg::REG_COLUMNS: grid_columns_q <= cfg_data[8:0];
				mfd_pkg::REG_ROWS:    grid_rows_q    <= cfg_data[8:0];
				mfd_pkg::REG_LENGTH:  cell_length_q  <= cfg_data[31:0];
				mfd_pkg::REG_AREA:    cell_area_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			i_q         <= '0;
			take_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CELL_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (s_tuser != mfd_pkg::REQ_NONE)) begin
						if (!in_inside || (s_tuser == mfd_pkg::REQ_WRITE)) begin
							state_q <= ST_REPLY;
						end else if (s_tuser == mfd_pkg::REQ_READ) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_CENTER;
						end
					end
				end
				ST_READ: state_q <= ST_REPLY;
				ST_CENTER: begin
					state_q <= elev_rd[32] ? ST_REPLY : ST_LEN;
					take_q  <= '0;
					i_q     <= '0;
				end
				ST_LEN: begin
					if (log_done) begin
						state_q <= ST_NADDR;
					end
				end
				ST_NADDR: begin
					if (nbr_in) begin
						state_q <= ST_NDATA;
					end else begin
						i_q     <= i_q + 3'd1;
						state_q <= (i_q == 3'd7) ? ST_WSTART : ST_NADDR;
					end
				end
				ST_NDATA: begin
					if (!elev_rd[32] && drop_pos) begin
						state_q <= ST_NLOG;
					end else begin
						i_q     <= i_q + 3'd1;
						state_q <= (i_q == 3'd7) ? ST_WSTART : ST_NADDR;
					end
				end
				ST_NLOG: begin
					if (log_done) begin
						state_q <= ST_NPOW;
					end
				end
				ST_NPOW: begin
					take_q[i_q] <= 1'b1;
					i_q         <= i_q + 3'd1;
					state_q     <= (i_q == 3'd7) ? ST_WSTART : ST_NADDR;
				end
				ST_WSTART: begin
					if (take_q[i_q]) begin
						state_q <= ST_WEXP;
					end else begin
						i_q     <= i_q + 3'd1;
						state_q <= (i_q == 3'd7) ? ST_WEND : ST_WSTART;
					end
				end
				ST_WEXP: begin
					if (exp_done) begin
						i_q     <= i_q + 3'd1;
						state_q <= (i_q == 3'd7) ? ST_WEND : ST_WSTART;
					end
				end
				ST_WEND: begin
					state_q <= (sum_q == '0) ? ST_REPLY : ST_UADDR;
				end
				ST_UADDR: begin
					if (take_q[i_q] && (w_q[i_q] != '0)) begin
						state_q <= ST_UMUL;
					end else begin
						i_q     <= i_q + 3'd1;
						state_q <= (i_q == 3'd7) ? ST_REPLY : ST_UADDR;
					end
				end
				ST_UMUL: state_q <= ST_UDIV;
				ST_UDIV: begin
					if (div_done) begin
						i_q     <= i_q + 3'd1;
						state_q <= (i_q == 3'd7) ? ST_REPLY : ST_UADDR;
					end
				end
				ST_REPLY: begin
					if (reply_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				kind_q      <= s_tuser;
				r_q         <= in_row;
				c_q         <= in_col;
				a_q         <= in_addr;
				reply_val_q <= '0;
			end
			ST_READ: reply_val_q <= flow_rd;
			ST_CENTER: begin
				elev_c_q <= elev_rd[31:0];
				f_q      <= mfd_pkg::sat_add(flow_rd, cell_area_q);
				emax_q   <= '0;
			end
			ST_LEN: begin
				if (log_done) begin
					len_log_q <= log_result;
				end
			end
			ST_NLOG: begin
				if (log_done) begin
					epow_s1 <= 41'(l_val) * 41'(mfd_pkg::POWER_Q16);
				end
			end
			ST_NPOW: begin
				e_q[i_q] <= epow_s1[16 +: EW];
				if (epow_s1[16 +: EW] > emax_q) begin
					emax_q <= epow_s1[16 +: EW];
				end
				sum_q <= '0;
			end
			ST_WSTART: begin
				shift_q <= shift_val;
				if (!take_q[i_q]) begin
					w_q[i_q] <= '0;
				end
			end
			ST_WEXP: begin
				if (exp_done) begin
					w_q[i_q] <= w_val;
					sum_q    <= sum_q + mfd_pkg::SUM_W'(w_val);
				end
			end
			ST_UADDR: mul_s1 <= 64'(f_q) * 64'(w_q[i_q]);
			ST_REPLY: begin
				if (reply_free) begin
					out_data_q <= reply_val_q;
					out_kind_q <= kind_q;
				end
			end
			default: begin
			end
		endcase
		if (state_q == ST_CENTER) begin
			sum_q <= '0;
		end
	end

	mfd_log2_unit u_log2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (log_start),
		.operand (log_operand),
		.done    (log_done),
		.result  (log_result)
	);

	mfd_exp2_unit u_exp2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exp_start),
		.frac   (x_dif[15:0]),
		.done   (exp_done),
		.result (exp_result)
	);

	mfd_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_s1),
		.divisor  (sum_q),
		.done     (div_done),
		.quotient (div_q)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;
endmodule

### hw/rtl/mfd_log2_unit.sv
// Iterative log2 in Q5.16: normalize by shifts of 16, 8, 4, 2 or 1 bits, then sixteen squarings.
module mfd_log2_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [31:0]                operand,
	output logic                       done,
	output logic [mfd_pkg::LOG_W-1:0]  result
);
	logic                        busy_q;
	logic                        norm_q;
	logic [31:0]                 n_q;
	logic [4:0]                  zeros_q;
	logic [mfd_pkg::MANT_W-1:0]  m_q;
	logic [15:0]                 frac_q;
	logic [3:0]                  cnt_q;
	logic                        done_q;
	logic [61:0]                 sq;
	logic [31:0]                 sq_t;

	assign sq   = 62'(m_q) * 62'(m_q);
	assign sq_t = sq[61:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			norm_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				norm_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q && norm_q) begin
				if (n_q[31]) begin
					norm_q <= 1'b0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q     <= (operand == 32'd0) ? 32'd1 : operand;
			zeros_q <= '0;
			frac_q  <= '0;
		end else if (busy_q && norm_q) begin
			priority if (n_q[31]) begin
				m_q <= n_q[31:1];
			end else if (n_q[31:16] == 16'd0) begin
				n_q     <= n_q << 16;
				zeros_q <= zeros_q + 5'd16;
			end else if (n_q[31:24] == 8'd0) begin
				n_q     <= n_q << 8;
				zeros_q <= zeros_q + 5'd8;
			end else if (n_q[31:28] == 4'd0) begin
				n_q     <= n_q << 4;
				zeros_q <= zeros_q + 5'd4;
			end else if (n_q[31:30] == 2'd0) begin
				n_q     <= n_q << 2;
				zeros_q <= zeros_q + 5'd2;
			end else begin
				n_q     <= n_q << 1;
				zeros_q <= zeros_q + 5'd1;
			end
		end else if (busy_q) begin
			if (sq_t[31]) begin
				m_q    <= sq_t[31:1];
				frac_q <= {frac_q[14:0], 1'b1};
			end else begin
				m_q    <= sq_t[30:0];
				frac_q <= {frac_q[14:0], 1'b0};
			end
		end
	end

	assign done   = done_q;
	assign result = {5'd31 - zeros_q, frac_q};
endmodule

### hw/rtl/mfd_exp2_unit.sv
// Iterative 2^frac in Q1.30: one root-table multiply per fraction bit.
module mfd_exp2_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [15:0]                frac,
	output logic                       done,
	output logic [mfd_pkg::MANT_W-1:0] result
);
	logic                        busy_q;
	logic                        done_q;
	logic [3:0]                  cnt_q;
	logic [15:0]                 f_q;
	logic [mfd_pkg::MANT_W-1:0]  m_q;
	logic [61:0]                 prod;

	assign prod = 62'(m_q) * 62'(mfd_pkg::ROOT_TABLE[cnt_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			f_q <= frac;
			m_q <= mfd_pkg::MANT_W'(1 << 30);
		end else if (busy_q) begin
			f_q <= f_q << 1;
			if (f_q[15]) begin
				m_q <= prod[30 +: mfd_pkg::MANT_W];
			end
		end
	end

	assign done   = done_q;
	assign result = m_q;
endmodule

### hw/rtl/mfd_divider.sv
// Restoring divider, one quotient bit a cycle, for the flow share.
module mfd_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mfd_pkg::PROD_W-1:0] dividend,
	input  logic [mfd_pkg::SUM_W-1:0]  divisor,
	output logic                       done,
	output logic [mfd_pkg::FLOW_W-1:0] quotient
);
	logic                        busy_q;
	logic                        done_q;
	logic [5:0]                  cnt_q;
	logic [mfd_pkg::PROD_W-1:0]  q_q;
	logic [mfd_pkg::SUM_W:0]     rem_q;
	logic [mfd_pkg::SUM_W-1:0]   d_q;
	logic [mfd_pkg::SUM_W:0]     rem_sh;

	assign rem_sh = {rem_q[mfd_pkg::SUM_W-1:0], q_q[mfd_pkg::PROD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			if (rem_sh >= {1'b0, d_q}) begin
				rem_q <= rem_sh - {1'b0, d_q};
				q_q   <= {q_q[mfd_pkg::PROD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				q_q   <= {q_q[mfd_pkg::PROD_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = q_q[mfd_pkg::FLOW_W-1:0];
endmodule
